[sv/pascal_subset_lexer_macros.svh]
// ----------------------------------------------------------------------------
// pascal_subset_lexer_macros
// Assertion macros for the lexer block.
// ----------------------------------------------------------------------------
`ifndef PASCAL_SUBSET_LEXER_MACROS_SVH
`define PASCAL_SUBSET_LEXER_MACROS_SVH
`ifndef SYNTHESIS
`define PSL_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PSL_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PSL_ASSERT(label, clk, rst_n, prop)
`define PSL_ASSERT_NR(label, clk, prop)
`endif
`endif

[sv/psl_pkg.sv]
// ----------------------------------------------------------------------------
// psl_pkg
// Token kinds, lexer modes and the result beat type shared by the lexer.
// ----------------------------------------------------------------------------
package psl_pkg;
    localparam int NUM_KW = 10;

    localparam logic [3:0] M_IDLE   = 4'd0;
    localparam logic [3:0] M_IDENT  = 4'd1;
    localparam logic [3:0] M_NUMBER = 4'd2;
    localparam logic [3:0] M_BADNUM = 4'd3;
    localparam logic [3:0] M_COLON  = 4'd4;
    localparam logic [3:0] M_LT     = 4'd5;
    localparam logic [3:0] M_GT     = 4'd6;
    localparam logic [3:0] M_SLASH  = 4'd7;
    localparam logic [3:0] M_LINE   = 4'd8;
    localparam logic [3:0] M_BRACE  = 4'd9;

    localparam logic [4:0] K_ERROR  = 5'd0;
    localparam logic [4:0] K_IDENT  = 5'd11;
    localparam logic [4:0] K_INT    = 5'd12;
    localparam logic [4:0] K_COMMA  = 5'd13;
    localparam logic [4:0] K_DOT    = 5'd14;
    localparam logic [4:0] K_COLON  = 5'd15;
    localparam logic [4:0] K_SEMI   = 5'd16;
    localparam logic [4:0] K_ADD    = 5'd17;
    localparam logic [4:0] K_SUB    = 5'd18;
    localparam logic [4:0] K_MUL    = 5'd19;
    localparam logic [4:0] K_ASSIGN = 5'd20;
    localparam logic [4:0] K_LE     = 5'd21;
    localparam logic [4:0] K_NE     = 5'd22;
    localparam logic [4:0] K_LT     = 5'd23;
    localparam logic [4:0] K_EQ     = 5'd24;
    localparam logic [4:0] K_GE     = 5'd25;
    localparam logic [4:0] K_GT     = 5'd26;
    localparam logic [4:0] K_DIV    = 5'd27;
    localparam logic [4:0] K_DECIMAL= 5'd28;
    localparam logic [4:0] K_UNDER  = 5'd29;

    // One token as classified by the front: kind and length, last flag
    typedef struct packed {
        logic [4:0] kind;
        logic [4:0] len;
        logic       last;
    } t_tok;

    // Keyword character at position pos (lower case), 0 past the end;
    // each word is left-justified in nine bytes, zero filled
    function automatic logic [7:0] kw_char(input int k, input int pos);
        logic [71:0] w;
        begin
            case (k)
                0: w = {"begin", 32'd0};
                1: w = {"end", 48'd0};
                2: w = {"var", 48'd0};
                3: w = {"integer", 16'd0};
                4: w = {"while", 32'd0};
                5: w = {"do", 56'd0};
                6: w = {"if", 56'd0};
                7: w = {"then", 40'd0};
                8: w = "procedure";
                default: w = {"else", 40'd0};
            endcase
            kw_char = (pos >= 0 && pos < 9) ? w[71 - 8 * pos -: 8] : 8'd0;
        end
    endfunction

    function automatic logic [3:0] kw_len(input int k);
        case (k)
            0: kw_len = 4'd5; 1: kw_len = 4'd3; 2: kw_len = 4'd3; 3: kw_len = 4'd7;
            4: kw_len = 4'd5; 5: kw_len = 4'd2; 6: kw_len = 4'd2; 7: kw_len = 4'd4;
            8: kw_len = 4'd9; default: kw_len = 4'd4;
        endcase
    endfunction
endpackage

[sv/psl_front.sv]
// ----------------------------------------------------------------------------
// psl_front
// Classifies one character per cycle unless stalled; pushes up to two beats.
// ----------------------------------------------------------------------------
module psl_front #(
    parameter int MAX_TOKEN_LEN = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_char,
    input  logic              i_end,
    output logic              o_ready,
    input  logic              i_space2,
    output logic              o_push,
    output logic              o_two,
    output psl_pkg::t_tok     o_tok0,
    output psl_pkg::t_tok     o_tok1
);
    import psl_pkg::*;

    localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [LW-1:0] LMAX = LW'(MAX_TOKEN_LEN);

    logic [3:0]        r_mode, n_mode;
    logic [NUM_KW-1:0] r_cand, n_cand;
    logic [LW-1:0]     r_len, n_len;
    logic [1:0]        r_dots, n_dots;

    logic        acc;
    logic        is_let, is_dig;
    logic [7:0]  lc;
    logic        close_v, start_v;
    logic [4:0]  close_k, start_k;
    logic [4:0]  close_l;
    logic        emit_v;
    logic [4:0]  emit_k;
    logic        do_close, do_start;
    logic [NUM_KW-1:0] cand_pos, cand_st;
    logic [3:0]  st_mode;
    logic [4:0]  len_sat;

    assign o_ready = i_space2;
    assign acc     = i_valid && o_ready;
    assign is_let  = (i_char >= 8'h61 && i_char <= 8'h7a) || (i_char >= 8'h41 && i_char <= 8'h5a);
    assign is_dig  = i_char >= 8'h30 && i_char <= 8'h39;
    assign lc      = (i_char >= 8'h41 && i_char <= 8'h5a) ? i_char + 8'd32 : i_char;
    assign len_sat = (r_len > LW'(31)) ? 5'd31 : 5'(r_len);

    // Narrow keyword mask at current position and at position zero
    always_comb begin
        for (int k = 0; k < NUM_KW; k++) begin
            cand_pos[k] = r_cand[k] && (r_len < LW'(kw_len(k)))
                          && (kw_char(k, int'(r_len[3:0])) == lc);
            cand_st[k]  = kw_char(k, 0) == lc;
        end
    end

    // Token kind when the open token is closed
    always_comb begin
        close_v = 1'b1;
        close_k = K_ERROR;
        close_l = 5'd1;
        case (r_mode)
            M_IDENT: begin
                close_k = K_IDENT;
                close_l = len_sat;
                for (int k = 0; k < NUM_KW; k++)
                    if (r_cand[k] && r_len == LW'(kw_len(k))) close_k = 5'(k + 1);
            end
            M_NUMBER: begin
                close_l = len_sat;
                close_k = (r_dots == 2'd0) ? K_INT : (r_dots == 2'd1) ? K_DECIMAL : K_ERROR;
            end
            M_BADNUM: close_l = len_sat;
            M_COLON:  close_k = K_COLON;
            M_LT:     close_k = K_LT;
            M_GT:     close_k = K_GT;
            M_SLASH:  close_k = K_DIV;
            default:  close_v = 1'b0;
        endcase
    end

    // Token started by the current character
    always_comb begin
        st_mode = M_IDLE;
        start_v = 1'b0;
        start_k = K_ERROR;
        if (is_let)      st_mode = M_IDENT;
        else if (is_dig) st_mode = M_NUMBER;
        else begin
            case (i_char)
                8'h3a: st_mode = M_COLON;
                8'h3c: st_mode = M_LT;
                8'h3e: st_mode = M_GT;
                8'h2f: st_mode = M_SLASH;
                8'h7b: st_mode = M_BRACE;
                8'h2c: begin start_v = 1'b1; start_k = K_COMMA; end
                8'h2e: begin start_v = 1'b1; start_k = K_DOT;   end
                8'h3b: begin start_v = 1'b1; start_k = K_SEMI;  end
                8'h2b: begin start_v = 1'b1; start_k = K_ADD;   end
                8'h2d: begin start_v = 1'b1; start_k = K_SUB;   end
                8'h2a: begin start_v = 1'b1; start_k = K_MUL;   end
                8'h3d: begin start_v = 1'b1; start_k = K_EQ;    end
                8'h5f: begin start_v = 1'b1; start_k = K_UNDER; end
                8'h20, 8'h0a, 8'h09: ;
                default: start_v = 1'b1;
            endcase
        end
    end

    // Mode transitions
    always_comb begin
        n_mode = r_mode; n_cand = r_cand; n_len = r_len; n_dots = r_dots;
        do_close = 1'b0; do_start = 1'b0;
        emit_v = 1'b0; emit_k = K_ERROR;
        if (i_end) do_close = 1'b1;
        else begin
            case (r_mode)
                M_IDENT:
                    if (is_let || is_dig) begin
                        n_cand = cand_pos;
                        if (r_len < LMAX) n_len = r_len + 1'b1;
                    end else begin do_close = 1'b1; do_start = 1'b1; end
                M_NUMBER:
                    if (is_dig || i_char == 8'h2e) begin
                        if (i_char == 8'h2e && r_dots != 2'd3) n_dots = r_dots + 2'd1;
                        if (r_len < LMAX) n_len = r_len + 1'b1;
                    end else if (is_let) begin
                        n_mode = M_BADNUM;
                        if (r_len < LMAX) n_len = r_len + 1'b1;
                    end else begin do_close = 1'b1; do_start = 1'b1; end
                M_BADNUM:
                    if (is_let) begin
                        if (r_len < LMAX) n_len = r_len + 1'b1;
                    end else begin do_close = 1'b1; do_start = 1'b1; end
                M_COLON:
                    if (i_char == 8'h3d) begin emit_v = 1'b1; emit_k = K_ASSIGN; end
                    else begin do_close = 1'b1; do_start = 1'b1; end
                M_LT:
                    if (i_char == 8'h3d) begin emit_v = 1'b1; emit_k = K_LE; end
                    else if (i_char == 8'h3e) begin emit_v = 1'b1; emit_k = K_NE; end
                    else begin do_close = 1'b1; do_start = 1'b1; end
                M_GT:
                    if (i_char == 8'h3d) begin emit_v = 1'b1; emit_k = K_GE; end
                    else begin do_close = 1'b1; do_start = 1'b1; end
                M_SLASH:
                    if (i_char == 8'h2f) begin n_mode = M_LINE; n_len = '0; end
                    else begin do_close = 1'b1; do_start = 1'b1; end
                M_LINE:  if (i_char == 8'h0a) n_mode = M_IDLE;
                M_BRACE: if (i_char == 8'h7d) n_mode = M_IDLE;
                default: do_start = 1'b1;
            endcase
        end
        if (emit_v || do_close) begin
            n_mode = M_IDLE; n_cand = '0; n_len = '0; n_dots = '0;
        end
        if (do_start) begin
            n_mode = st_mode; n_dots = '0;
            n_cand = (st_mode == M_IDENT) ? cand_st : '0;
            n_len  = (st_mode == M_IDLE || st_mode == M_BRACE) ? '0 : LW'(1);
        end
    end

    // Pack the up to two beats of this character
    always_comb begin
        logic v0, v1;
        v0 = emit_v || (do_close && close_v);
        v1 = do_start && start_v;
        o_tok0 = '0; o_tok1 = '0;
        o_two  = v0 && v1;
        o_push = acc && (v0 || v1);
        if (emit_v) begin
            o_tok0.kind = emit_k; o_tok0.len = 5'd2;
        end else if (v0) begin
            o_tok0.kind = close_k; o_tok0.len = close_l;
        end else begin
            o_tok0.kind = start_k; o_tok0.len = 5'd1;
        end
        o_tok0.last = !o_two;
        o_tok1.kind = start_k; o_tok1.len = 5'd1; o_tok1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_cand <= '0; r_len <= '0; r_dots <= '0;
        end else if (acc) begin
            r_mode <= n_mode; r_cand <= n_cand; r_len <= n_len; r_dots <= n_dots;
        end
    end

    `include "pascal_subset_lexer_macros.svh"
    `PSL_ASSERT(a_len_cap, i_clk, i_rst_n, r_len <= LMAX)
    `PSL_ASSERT(a_cand_ident, i_clk, i_rst_n, (r_cand != '0) |-> (r_mode == M_IDENT))
    `PSL_ASSERT(a_no_push_full, i_clk, i_rst_n, !i_space2 |-> !o_push)
endmodule

[sv/psl_back.sv]
// ----------------------------------------------------------------------------
// psl_back
// Token queue, error counter and the output beat register.
// ----------------------------------------------------------------------------
module psl_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_two,
    input  psl_pkg::t_tok i_tok0,
    input  psl_pkg::t_tok i_tok1,
    output logic          o_space2,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [4:0]    o_kind,
    output logic [4:0]    o_len,
    output logic [15:0]   o_err,
    output logic          o_last
);
    import psl_pkg::*;

    localparam int DEPTH = 4;

    t_tok        r_q [DEPTH];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_cnt, n_cnt;
    logic [15:0] r_err;
    logic        pop;
    t_tok        head;

    assign o_space2 = r_cnt <= 3'(DEPTH - 2);
    assign pop      = (r_cnt != 3'd0) && (!o_valid || i_ready);
    assign head     = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push) n_cnt = n_cnt + (i_two ? 3'd2 : 3'd1);
        if (pop)    n_cnt = n_cnt - 3'd1;
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_tok0;
            if (i_two) r_q[r_wp + 2'd1] <= i_tok1;
        end
    end

    // Pointers, counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_err <= '0; o_valid <= 1'b0;
        end else begin
            if (i_push) r_wp <= r_wp + (i_two ? 2'd2 : 2'd1);
            r_cnt <= n_cnt;
            if (pop) begin
                r_rp    <= r_rp + 2'd1;
                o_valid <= 1'b1;
                if (head.kind == K_ERROR && r_err != 16'hffff) r_err <= r_err + 16'd1;
            end else if (i_ready) o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            o_kind <= head.kind;
            o_len  <= head.len;
            o_last <= head.last;
            o_err  <= (head.kind == K_ERROR && r_err != 16'hffff) ? r_err + 16'd1 : r_err;
        end
    end

    `include "pascal_subset_lexer_macros.svh"
    `PSL_ASSERT(a_cnt_cap, i_clk, i_rst_n, r_cnt <= 3'(DEPTH))
    `PSL_ASSERT(a_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> $stable(o_kind))
    `PSL_ASSERT(a_err_mono, i_clk, i_rst_n, r_err >= $past(r_err) || $past(!i_rst_n))
endmodule

[sv/pascal_subset_lexer.sv]
// Result path: the character that ends a token writes its beats into the token queue,
// from which they move to the output beat register. Throughput: one character per cycle;
// a character may yield two beats, drained one per cycle from a four-entry token queue
// while the receiver is ready; the input stalls while the queue holds more than two.
// Reset: synchronous active low; lexer goes idle, queue empties, error count clears.
// ----------------------------------------------------------------------------
// pascal_subset_lexer
// Streaming lexer for a small Pascal-like language, one byte per beat.
// ----------------------------------------------------------------------------
module pascal_subset_lexer #(
    parameter int MAX_TOKEN_LEN = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [4:0] token_kind, [9:5] token_length,
                                        // [25:10] error_total, [31:26] zero
    output logic        m_axis_tlast    // last_of_run
);
    import psl_pkg::*;

    logic push, two, space2;
    t_tok tok0, tok1;
    logic [4:0]  kind, len;
    logic [15:0] err;

    psl_front #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .i_char(s_axis_tdata), .i_end(s_axis_tlast),
        .o_ready(s_axis_tready), .i_space2(space2),
        .o_push(push), .o_two(two), .o_tok0(tok0), .o_tok1(tok1)
    );

    psl_back u_back (
        .i_clk, .i_rst_n,
        .i_push(push), .i_two(two), .i_tok0(tok0), .i_tok1(tok1),
        .o_space2(space2),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_kind(kind), .o_len(len), .o_err(err), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, err, len, kind};
endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lexer: feeds byte streams built from source
// fragments, keywords, numbers, operators, comments and random bytes,
// predicts each token beat and compares every output beat field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import psl_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic       eoi;
        logic [7:0] ch;
    } t_char;

    typedef struct packed {
        logic [4:0]  kind;
        logic [4:0]  len;
        logic [15:0] errs;
        logic        last;
    } t_token;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] char_code
    logic        s_axis_tlast;   // end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [4:0] kind, [9:5] length, [25:10] errors
    logic        m_axis_tlast;   // last_of_run

    pascal_subset_lexer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Lexer shadow state
    logic [3:0]  lx_mode;
    logic [9:0]  lx_cand;
    logic [4:0]  lx_len;
    logic [1:0]  lx_dots;
    logic [15:0] lx_errs;
    t_token      beat_buf[$];

    t_char   char_queue[$];
    t_token  token_queue[$];
    int      n_mismatch;
    int      n_beats;
    int      n_chars;
    int      n_errtok;
    int      idle_cycles;
    bit      hold_for_drain;
    bit      stim_done;
    int      burst_left;
    int      gap_left;
    int      stall_phase;

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic string kw_word(int k);
        case (k)
            0: return "begin";   1: return "end";  2: return "var";
            3: return "integer"; 4: return "while"; 5: return "do";
            6: return "if";      7: return "then"; 8: return "procedure";
            default: return "else";
        endcase
    endfunction

    task automatic push_token(logic [4:0] kind, int len);
        t_token t;
        if (kind == K_ERROR && lx_errs != 16'hFFFF) lx_errs++;
        if (len > 31) len = 31;
        t.kind = kind;
        t.len  = len[4:0];
        t.errs = lx_errs;
        t.last = 1'b0;
        beat_buf.push_back(t);
    endtask

    // Drop candidates that disagree with character c at position pos
    task automatic narrow_cand(int pos, logic [7:0] c);
        string w;
        logic [7:0] lc;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        for (int k = 0; k < NUM_KW; k++) begin
            w = kw_word(k);
            if (lx_cand[k] && (pos >= w.len() || w[pos] != lc)) lx_cand[k] = 1'b0;
        end
    endtask

    task automatic lengthen();
        if (lx_len < 5'd31) lx_len++;
    endtask

    task automatic flush_token();
        logic [4:0] kind;
        string w;
        case (lx_mode)
            M_IDENT: begin
                kind = K_IDENT;
                for (int k = 0; k < NUM_KW; k++) begin
                    w = kw_word(k);
                    if (lx_cand[k] && w.len() == lx_len) kind = 5'(k + 1);
                end
                push_token(kind, lx_len);
            end
            M_NUMBER: push_token(lx_dots == 0 ? K_INT :
                                 (lx_dots == 1 ? K_DECIMAL : K_ERROR), lx_len);
            M_BADNUM: push_token(K_ERROR, lx_len);
            M_COLON:  push_token(K_COLON, 1);
            M_LT:     push_token(K_LT, 1);
            M_GT:     push_token(K_GT, 1);
            M_SLASH:  push_token(K_DIV, 1);
            default: ;
        endcase
        lx_mode = M_IDLE;
        lx_cand = '0;
        lx_len  = '0;
        lx_dots = '0;
    endtask

    task automatic open_token(logic [7:0] c);
        lx_mode = M_IDLE;
        lx_cand = '0;
        lx_len  = '0;
        lx_dots = '0;
        if (is_alpha(c)) begin
            lx_mode = M_IDENT;
            lx_cand = '1;
            narrow_cand(0, c);
            lx_len = 1;
        end else if (is_num(c)) begin
            lx_mode = M_NUMBER;
            lx_len = 1;
        end else begin
            case (c)
                ":": begin lx_mode = M_COLON; lx_len = 1; end
                "<": begin lx_mode = M_LT;    lx_len = 1; end
                ">": begin lx_mode = M_GT;    lx_len = 1; end
                "/": begin lx_mode = M_SLASH; lx_len = 1; end
                "{": lx_mode = M_BRACE;
                ",": push_token(K_COMMA, 1);
                ".": push_token(K_DOT, 1);
                ";": push_token(K_SEMI, 1);
                "+": push_token(K_ADD, 1);
                "-": push_token(K_SUB, 1);
                "*": push_token(K_MUL, 1);
                "=": push_token(K_EQ, 1);
                "_": push_token(K_UNDER, 1);
                " ", 8'h0A, 8'h09: ;
                default: push_token(K_ERROR, 1);
            endcase
        end
    endtask

    // Advance the shadow lexer by one accepted beat and queue its tokens
    task automatic lex_char(t_char in);
        logic [7:0] c;
        c = in.ch;
        beat_buf.delete();
        if (in.eoi) begin
            flush_token();
        end else begin
            case (lx_mode)
                M_IDENT:
                    if (is_alpha(c) || is_num(c)) begin
                        narrow_cand(lx_len, c);
                        lengthen();
                    end else begin
                        flush_token(); open_token(c);
                    end
                M_NUMBER:
                    if (is_num(c) || c == ".") begin
                        if (c == "." && lx_dots < 3) lx_dots++;
                        lengthen();
                    end else if (is_alpha(c)) begin
                        lx_mode = M_BADNUM;
                        lengthen();
                    end else begin
                        flush_token(); open_token(c);
                    end
                M_BADNUM:
                    if (is_alpha(c)) lengthen();
                    else begin flush_token(); open_token(c); end
                M_COLON:
                    if (c == "=") begin push_token(K_ASSIGN, 2); open_token(" "); end
                    else begin flush_token(); open_token(c); end
                M_LT:
                    if (c == "=") begin push_token(K_LE, 2); open_token(" "); end
                    else if (c == ">") begin push_token(K_NE, 2); open_token(" "); end
                    else begin flush_token(); open_token(c); end
                M_GT:
                    if (c == "=") begin push_token(K_GE, 2); open_token(" "); end
                    else begin flush_token(); open_token(c); end
                M_SLASH:
                    if (c == "/") begin lx_mode = M_LINE; lx_len = 0; end
                    else begin flush_token(); open_token(c); end
                M_LINE:  if (c == 8'h0A) lx_mode = M_IDLE;
                M_BRACE: if (c == "}") lx_mode = M_IDLE;
                default: open_token(c);
            endcase
        end
        if (beat_buf.size() > 0) beat_buf[beat_buf.size() - 1].last = 1'b1;
        foreach (beat_buf[i]) token_queue.push_back(beat_buf[i]);
    endtask

    task automatic add_text(string s);
        t_char c;
        for (int i = 0; i < s.len(); i++) begin
            c.eoi = 1'b0;
            c.ch  = s[i];
            char_queue.push_back(c);
        end
    endtask

    task automatic add_byte(logic [7:0] b, logic eoi);
        t_char c;
        c.ch  = b;
        c.eoi = eoi;
        char_queue.push_back(c);
    endtask

    // Random case flips so keyword matching sees mixed case
    function automatic string mix_case(string s);
        string r;
        r = s;
        for (int i = 0; i < r.len(); i++)
            if ($urandom_range(1, 0) && r[i] >= "a" && r[i] <= "z") r[i] = r[i] - 8'd32;
        return r;
    endfunction

    function automatic string rand_word();
        string s;
        int n;
        s = "";
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++)
            s = {s, string'(8'($urandom_range(2, 0) == 0 ? $urandom_range("9", "0")
                                                         : $urandom_range("z", "a")))};
        s[0] = 8'($urandom_range("z", "a"));
        return s;
    endfunction

    // One fragment of plausible source, with some malformed pieces mixed in
    task automatic add_fragment();
        string s;
        int sel;
        sel = $urandom_range(19, 0);
        case (sel)
            0, 1, 2: s = mix_case(kw_word($urandom_range(9, 0)));
            3, 4:    s = mix_case(rand_word());
            5:       s = $sformatf("%0d", $urandom_range(99999, 0));
            6:       s = $sformatf("%0d.%0d", $urandom_range(999, 0), $urandom_range(99, 0));
            7:       s = "1.2.3";
            8:       s = {$sformatf("%0d", $urandom_range(99, 0)), "ab"};
            9:       s = ":=";
            10: begin
                case ($urandom_range(5, 0))
                    0: s = "<=";  1: s = "<>";  2: s = ">=";
                    3: s = "<";   4: s = ">";   default: s = ":";
                endcase
            end
            11: begin
                case ($urandom_range(9, 0))
                    0: s = ","; 1: s = "."; 2: s = ";"; 3: s = "+"; 4: s = "-";
                    5: s = "*"; 6: s = "="; 7: s = "_"; 8: s = "/"; default: s = "}";
                endcase
            end
            12: s = {"// ", rand_word(), "\n"};
            13: s = {"{ ", rand_word(), " }"};
            14: s = {mix_case(kw_word($urandom_range(9, 0))), rand_word()};
            15: s = "\t";
            16: s = "\n";
            default: s = " ";
        endcase
        add_text(s);
        if (sel < 15 && $urandom_range(2, 0) != 0) add_text(" ");
    endtask

    // Stimulus
    initial begin
        string long_id;
        i_rst_n = 1'b0;
        lx_mode = M_IDLE; lx_cand = '0; lx_len = '0; lx_dots = '0; lx_errs = '0;
        n_mismatch = 0; n_beats = 0; n_chars = 0; n_errtok = 0;
        hold_for_drain = 1'b0;
        stim_done = 1'b0;

        // Directed: keywords in mixed case, operators, comments, error cases
        add_text("BEGIN x1:=12.5;ProCedure<>3..4 7ab+");
        add_text("{c}//z\n}");
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        long_id = "abcdefghijklmnopqrstuvwxyzabcdefghij";
        add_text("beginx ");
        add_text(long_id);
        add_byte(8'h00, 1'b1);
        add_text("<");
        add_byte(8'hFF, 1'b1);
        add_text("{open");
        add_byte(8'h55, 1'b1);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (char_queue.size() == 0);
        // Let the whole directed part drain before going random
        hold_for_drain = 1'b1;
        wait (token_queue.size() == 0);
        repeat (8) @(posedge i_clk);
        hold_for_drain = 1'b0;

        while (n_chars < 1500) begin
            if (char_queue.size() < 16) begin
                if ($urandom_range(15, 0) == 0)
                    add_byte(8'($urandom_range(255, 0)), 1'b0);
                else if ($urandom_range(60, 0) == 0)
                    add_byte(8'($urandom_range(255, 0)), 1'b1);
                else
                    add_fragment();
            end
            @(posedge i_clk);
        end
        add_byte(8'h20, 1'b1);
        wait (char_queue.size() == 0);
        stim_done = 1'b1;
    end

    // Driver: bursts of beats separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            burst_left    <= 0;
            gap_left      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                lex_char(char_queue.pop_front());
                n_chars <= n_chars + 1;
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the current beat
            end else if (gap_left > 0) begin
                gap_left      <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (burst_left == 0) begin
                burst_left    <= $urandom_range(40, 1);
                gap_left      <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                s_axis_tvalid <= 1'b0;
            end else if (char_queue.size() > 0 && !hold_for_drain) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= char_queue[0].ch;
                s_axis_tlast  <= char_queue[0].eoi;
                burst_left    <= burst_left - 1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern and result check
    always @(posedge i_clk) begin
        t_token exp_tok;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_phase   <= 0;
            idle_cycles   <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[9:8] == 2'd0)
                m_axis_tready <= 1'b1;
            else if (stall_phase[9:8] == 2'd1)
                m_axis_tready <= (stall_phase % 3) != 0;
            else
                m_axis_tready <= $urandom_range(3, 0) != 0;

            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;

            if (m_axis_tvalid && m_axis_tready) begin
                n_beats <= n_beats + 1;
                if (token_queue.size() == 0) begin
                    n_mismatch = n_mismatch + 1;
                    if (n_mismatch <= 10)
                        $display("unexpected token beat kind=%0d len=%0d errs=%0d last=%0b",
                                 m_axis_tdata[4:0], m_axis_tdata[9:5],
                                 m_axis_tdata[25:10], m_axis_tlast);
                end else begin
                    exp_tok = token_queue.pop_front();
                    if (exp_tok.kind == K_ERROR) n_errtok <= n_errtok + 1;
                    if (m_axis_tdata[4:0] !== exp_tok.kind ||
                        m_axis_tdata[9:5] !== exp_tok.len ||
                        m_axis_tdata[25:10] !== exp_tok.errs ||
                        m_axis_tdata[31:26] !== 6'd0 ||
                        m_axis_tlast !== exp_tok.last) begin
                        n_mismatch = n_mismatch + 1;
                        if (n_mismatch <= 10)
                            $display("token mismatch: exp kind=%0d len=%0d errs=%0d last=%0b",
                                     exp_tok.kind, exp_tok.len, exp_tok.errs, exp_tok.last,
                                     " got kind=%0d len=%0d errs=%0d last=%0b",
                                     m_axis_tdata[4:0], m_axis_tdata[9:5],
                                     m_axis_tdata[25:10], m_axis_tlast);
                    end
                end
            end
        end
    end

    // Watchdog
    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // End of run
    initial begin
        wait (stim_done);
        wait (token_queue.size() == 0);
        repeat (20) @(posedge i_clk);
        $display("Lexed %0d characters into %0d token beats (%0d error tokens),",
                 n_chars, n_beats, n_errtok);
        $display("with keywords, numbers, operators, comments and raw bytes; %0d mismatches.",
                 n_mismatch);
        if (n_mismatch == 0 && token_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
